FILE: design/wsfp_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none
package wsfp_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic STATUS_COMPLETE = 1'b0;
  localparam logic STATUS_SHORT    = 1'b1;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  // One decoded request: an optional payload byte, an optional status.
  typedef struct packed {
    logic        has_payload;
    logic        has_status;
    logic [7:0]  payload_byte;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic        status;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/wsfp_front.sv
// Header parser and unmasker: turns payload and end-of-buffer bytes into queue entries.
`default_nettype none
module wsfp_front import wsfp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_buffer,
  output logic            push,
  output entry_t          push_entry
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  rsv_r, rsv_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] done_r, done_nxt;

  logic        accept;
  logic        emit_payload;
  logic [7:0]  key_byte;
  logic [3:0]  cnt_dec;
  logic        len_known;
  logic        complete;

  assign accept  = in_valid && !in_stall;
  assign cnt_dec = (cnt_r != 4'd0) ? cnt_r - 4'd1 : cnt_r;

  always_comb begin
    case (done_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    fin_nxt      = fin_r;
    rsv_nxt      = rsv_r;
    opc_nxt      = opc_r;
    mask_nxt     = mask_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    done_nxt     = done_r;
    emit_payload = 1'b0;
    case (phase_r)
      PH_HDR0: begin
        fin_nxt   = in_data_byte[7];
        rsv_nxt   = in_data_byte[6:4];
        opc_nxt   = in_data_byte[3:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt = in_data_byte[7];
        len_nxt  = 64'd0;
        if (in_data_byte[6:0] == LEN_CODE_16) begin
          phase_nxt = PH_EXT;
          cnt_nxt   = EXT_BYTES_16;
        end else if (in_data_byte[6:0] == LEN_CODE_64) begin
          phase_nxt = PH_EXT;
          cnt_nxt   = EXT_BYTES_64;
        end else begin
          len_nxt   = {57'd0, in_data_byte[6:0]};
          phase_nxt = in_data_byte[7] ? PH_KEY : PH_DATA;
          cnt_nxt   = in_data_byte[7] ? KEY_BYTES : 4'd0;
        end
      end
      PH_EXT: begin
        len_nxt = {len_r[55:0], in_data_byte};
        cnt_nxt = cnt_dec;
        if (cnt_dec == 4'd0) begin
          phase_nxt = mask_r ? PH_KEY : PH_DATA;
          cnt_nxt   = mask_r ? KEY_BYTES : 4'd0;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], in_data_byte};
        cnt_nxt = cnt_dec;
        if (cnt_dec == 4'd0) begin
          phase_nxt = PH_DATA;
        end
      end
      default: begin
        if (done_r < len_r) begin
          emit_payload = 1'b1;
          done_nxt     = done_r + 64'd1;
        end
      end
    endcase
  end

  assign len_known = (phase_nxt == PH_KEY) || (phase_nxt == PH_DATA);
  assign complete  = (phase_nxt == PH_DATA) && (done_nxt == len_nxt);

  always_comb begin
    push_entry.has_payload  = emit_payload;
    push_entry.has_status   = in_end_of_buffer;
    push_entry.payload_byte = mask_r ? (in_data_byte ^ key_byte) : in_data_byte;
    push_entry.fin          = fin_nxt;
    push_entry.rsv          = rsv_nxt;
    push_entry.opcode       = opc_nxt;
    push_entry.masked       = mask_nxt;
    push_entry.length       = len_known ? len_nxt : 64'd0;
    push_entry.status       = complete ? STATUS_COMPLETE : STATUS_SHORT;
  end

  assign push = accept && (emit_payload || in_end_of_buffer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      cnt_r   <= 4'd0;
      fin_r   <= 1'b0;
      rsv_r   <= 3'd0;
      opc_r   <= 4'd0;
      mask_r  <= 1'b0;
      len_r   <= 64'd0;
      key_r   <= 32'd0;
      done_r  <= 64'd0;
    end else if (accept) begin
      if (in_end_of_buffer) begin
        phase_r <= PH_HDR0;
        cnt_r   <= 4'd0;
        fin_r   <= 1'b0;
        rsv_r   <= 3'd0;
        opc_r   <= 4'd0;
        mask_r  <= 1'b0;
        len_r   <= 64'd0;
        key_r   <= 32'd0;
        done_r  <= 64'd0;
      end else begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        fin_r   <= fin_nxt;
        rsv_r   <= rsv_nxt;
        opc_r   <= opc_nxt;
        mask_r  <= mask_nxt;
        len_r   <= len_nxt;
        key_r   <= key_nxt;
        done_r  <= done_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/wsfp_queue.sv
// Small register queue between the parser and the result stage.
`default_nettype none
module wsfp_queue import wsfp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        head_valid,
  output logic        full
);

  entry_t           slot_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   count_r;
  logic             do_pop;

  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == QCW'(QDEPTH));
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + QCW'(1);
        2'b01:   count_r <= count_r - QCW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/wsfp_back.sv
// Result stage: splits queue entries into payload and status results.
`default_nettype none
module wsfp_back import wsfp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire entry_t       head,
  input  wire logic         head_valid,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_result_kind,
  output logic [7:0]        out_payload_byte,
  output logic              out_fin_flag,
  output logic [2:0]        out_reserved_bits,
  output logic [3:0]        out_frame_opcode,
  output logic              out_masked_flag,
  output logic [63:0]       out_payload_length,
  output logic              out_frame_status,
  output logic              out_last_of_run
);

  logic        valid_r;
  logic        second_r, second_nxt;
  logic        load;
  logic        send_payload;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic        fin_r;
  logic [2:0]  rsv_r;
  logic [3:0]  opc_r;
  logic        mask_r;
  logic [63:0] len_r;
  logic        status_r;
  logic        last_r;

  assign load         = head_valid && (!valid_r || !out_stall);
  assign send_payload = head.has_payload && !second_r;
  assign pop          = load && !(send_payload && head.has_status);
  assign second_nxt   = load ? (send_payload && head.has_status) : second_r;

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= send_payload ? KIND_PAYLOAD : KIND_STATUS;
      byte_r   <= send_payload ? head.payload_byte : 8'd0;
      fin_r    <= head.fin;
      rsv_r    <= head.rsv;
      opc_r    <= head.opcode;
      mask_r   <= head.masked;
      len_r    <= head.length;
      status_r <= send_payload ? STATUS_COMPLETE : head.status;
      last_r   <= !(send_payload && head.has_status);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_result_kind    = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_fin_flag       = fin_r;
  assign out_reserved_bits  = rsv_r;
  assign out_frame_opcode   = opc_r;
  assign out_masked_flag    = mask_r;
  assign out_payload_length = len_r;
  assign out_frame_status   = status_r;
  assign out_last_of_run    = last_r;

endmodule
`default_nettype wire

FILE: design/websocket_frame_parser_unit.sv
// Top level of the WebSocket frame deframer.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_data_byte, ...   | byte in
//  out     | out_valid, out_stall, out_result_kind.. | result out
//
// One byte per cycle while in_stall is low; a byte that ends a buffer during payload
// gives two results, a payload result and then a status result.
// The result of an accepted byte is written to the queue and then to the output
// register. A four-entry queue lets the parser run on while out is stalled;
// in_stall rises only when the queue is full.
// rst_n is synchronous, active low, and returns the parser to the first
// header byte.
`default_nettype none
module websocket_frame_parser_unit import wsfp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_end_of_buffer,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_result_kind,
  output logic [7:0]        out_payload_byte,
  output logic              out_fin_flag,
  output logic [2:0]        out_reserved_bits,
  output logic [3:0]        out_frame_opcode,
  output logic              out_masked_flag,
  output logic [63:0]       out_payload_length,
  output logic              out_frame_status,
  output logic              out_last_of_run
);

  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   head_valid;
  logic   full;

  assign in_stall = full;

  wsfp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (full),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .push             (push),
    .push_entry       (push_entry)
  );

  wsfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  wsfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .head_valid         (head_valid),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_payload_byte   (out_payload_byte),
    .out_fin_flag       (out_fin_flag),
    .out_reserved_bits  (out_reserved_bits),
    .out_frame_opcode   (out_frame_opcode),
    .out_masked_flag    (out_masked_flag),
    .out_payload_length (out_payload_length),
    .out_frame_status   (out_frame_status),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
`default_nettype wire
